### src/csu_pkg.sv
// Shared types and constants for the CAN signal unpacker.
// Used by csu_extract and can_signal_unpack; depends on nothing else.
`default_nettype none

package csu_pkg;

  localparam int ID_W       = 29;
  localparam int LEN_W      = 4;
  localparam int PAY_W      = 64;
  localparam int SB_W       = 6;
  localparam int BL_W       = 7;
  localparam int FACT_W     = 32;
  localparam int OFF_W      = 48;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W     = PAY_W + FACT_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 136;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_ID_MISMATCH  = 2'd1,
    STATUS_LEN_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_ID     = 3'd0,
    REG_EXPECTED_LENGTH = 3'd1,
    REG_START_BIT       = 3'd2,
    REG_BIT_LENGTH      = 3'd3,
    REG_INTEL_ORDER     = 3'd4,
    REG_SIGNED_VALUE    = 3'd5,
    REG_FACTOR_Q16      = 3'd6,
    REG_OFFSET_Q16      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]   expected_id;
    logic [LEN_W-1:0]  expected_length;
    logic [SB_W-1:0]   start_bit;
    logic [BL_W-1:0]   bit_length;
    logic              intel_order;
    logic              signed_value;
    logic [FACT_W-1:0] factor_q16;
    logic [OFF_W-1:0]  offset_q16;
  } cfg_t;

  typedef struct packed {
    logic [PAY_W-1:0] raw;
    logic [PAY_W-1:0] maxmag;
  } ext_t;

endpackage

`default_nettype wire

### src/csu_extract.sv
// Bit field extraction in Intel or Motorola order, with sign extension.
// Uses csu_pkg for the configuration and result structs.
`default_nettype none

module csu_extract (
  input  csu_pkg::cfg_t                cfg_i,
  input  logic [csu_pkg::PAY_W-1:0]    payload_i,
  output csu_pkg::ext_t                ext_o
);

  logic [csu_pkg::BL_W-1:0]    len_eff;
  logic [csu_pkg::SB_W-1:0]    top_idx;
  logic [csu_pkg::PAY_W-1:0]   mask;
  logic [csu_pkg::PAY_W-1:0]   rev;
  logic [csu_pkg::SB_W-1:0]    sb_flip;
  logic [csu_pkg::BL_W-1:0]    t2;
  logic [2*csu_pkg::PAY_W-1:0] moto_wide;
  logic [csu_pkg::PAY_W-1:0]   intel_raw;
  logic [csu_pkg::PAY_W-1:0]   raw_m;
  logic                        sign;

  always_comb begin
    if (cfg_i.bit_length == '0) begin
      len_eff = csu_pkg::BL_W'(1);
    end else if (cfg_i.bit_length > csu_pkg::BL_W'(csu_pkg::PAY_W)) begin
      len_eff = csu_pkg::BL_W'(csu_pkg::PAY_W);
    end else begin
      len_eff = cfg_i.bit_length;
    end
  end

  // A full 64-bit width wraps the shift to zero, so the mask becomes all ones.
  assign mask    = (csu_pkg::PAY_W'(1) << len_eff) - csu_pkg::PAY_W'(1);
  assign top_idx = csu_pkg::SB_W'(len_eff - csu_pkg::BL_W'(1));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[8*j +: 8] = payload_i[8*(7-j) +: 8];
    end
  end

  // The Motorola field starts at bit 63 - t2 of the byte-reversed payload;
  // padding below it lets positions before byte 0 read as zero.
  assign sb_flip   = {cfg_i.start_bit[5:3], ~cfg_i.start_bit[2:0]};
  assign t2        = csu_pkg::BL_W'(sb_flip) + len_eff - csu_pkg::BL_W'(1);
  assign moto_wide = {rev, {csu_pkg::PAY_W{1'b0}}} >> (~t2);
  assign intel_raw = payload_i >> cfg_i.start_bit;

  assign raw_m = (cfg_i.intel_order ? intel_raw : moto_wide[csu_pkg::PAY_W-1:0]) & mask;
  assign sign  = cfg_i.signed_value & raw_m[top_idx];

  assign ext_o.raw    = sign ? (raw_m | ~mask) : raw_m;
  assign ext_o.maxmag = cfg_i.signed_value ? (mask >> 1) : mask;

endmodule

`default_nettype wire

### src/can_signal_unpack.sv
// Top level of the CAN signal unpacker: frame check, extraction and scaling.
// Depends on csu_pkg and csu_extract.
//
//   Channel   | Direction | Contents
//   cfg       | in        | write enable, register index, write data
//   s_axis    | in        | frame_id, frame_length, payload
//   m_axis    | out       | status, raw_value, scaled_value
//
// One frame is accepted per cycle while the output is not stalled; its result passes
// through stages B, C, D and the output stage, one step each: the extraction, the two 32x32
// partial products, the 96-bit product sum, and the offset add with saturation.
// Reset loads the register defaults and empties the pipeline.
// Each stage holds its transaction while the stage after it is full and cannot pass its
// own on, so a stalled output still lets the input side fill the empty stages.
`default_nettype none

module can_signal_unpack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [csu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [csu_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_id [28:0], frame_length [32:29], payload [96:33], zero fill
  input  logic [csu_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status [1:0], raw_value [65:2], scaled_value [129:66], zero fill
  output logic [csu_pkg::OUT_W-1:0]         m_axis_tdata
);

  csu_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id     <= '0;
      cfg_q.expected_length <= csu_pkg::LEN_W'(8);
      cfg_q.start_bit       <= '0;
      cfg_q.bit_length      <= csu_pkg::BL_W'(8);
      cfg_q.intel_order     <= 1'b1;
      cfg_q.signed_value    <= 1'b0;
      cfg_q.factor_q16      <= csu_pkg::FACT_W'(65536);
      cfg_q.offset_q16      <= '0;
    end else if (cfg_we_i) begin
      case (csu_pkg::reg_idx_e'(cfg_idx_i))
        csu_pkg::REG_EXPECTED_ID:     cfg_q.expected_id     <= cfg_wdata_i[csu_pkg::ID_W-1:0];
        csu_pkg::REG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_wdata_i[csu_pkg::LEN_W-1:0];
        csu_pkg::REG_START_BIT:       cfg_q.start_bit       <= cfg_wdata_i[csu_pkg::SB_W-1:0];
        csu_pkg::REG_BIT_LENGTH:      cfg_q.bit_length      <= cfg_wdata_i[csu_pkg::BL_W-1:0];
        csu_pkg::REG_INTEL_ORDER:     cfg_q.intel_order     <= cfg_wdata_i[0];
        csu_pkg::REG_SIGNED_VALUE:    cfg_q.signed_value    <= cfg_wdata_i[0];
        csu_pkg::REG_FACTOR_Q16:      cfg_q.factor_q16      <= cfg_wdata_i[csu_pkg::FACT_W-1:0];
        csu_pkg::REG_OFFSET_Q16:      cfg_q.offset_q16      <= cfg_wdata_i[csu_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and the ready chain.
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, o_valid_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  assign rdy_o = !o_valid_q || m_axis_tready;
  assign rdy_d = !d_valid_q || rdy_o;
  assign rdy_c = !c_valid_q || rdy_d;
  assign rdy_b = !b_valid_q || rdy_c;
  assign rdy_a = !a_valid_q || rdy_b;
  assign s_axis_tready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (rdy_a) a_valid_q <= s_axis_tvalid;
      if (rdy_b) b_valid_q <= a_valid_q;
      if (rdy_c) c_valid_q <= b_valid_q;
      if (rdy_d) d_valid_q <= c_valid_q;
      if (rdy_o) o_valid_q <= d_valid_q;
    end
  end

  // Stage A: input register.
  logic [csu_pkg::ID_W-1:0]  a_id_q;
  logic [csu_pkg::LEN_W-1:0] a_len_q;
  logic [csu_pkg::PAY_W-1:0] a_payload_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid) begin
      a_id_q      <= s_axis_tdata[28:0];
      a_len_q     <= s_axis_tdata[32:29];
      a_payload_q <= s_axis_tdata[96:33];
    end
  end

  csu_pkg::ext_t               ext;
  csu_pkg::status_e            b_status_d;
  logic                        f_neg;
  logic [csu_pkg::FACT_W-1:0]  f_mag;
  logic                        raw_neg;
  logic [csu_pkg::PAY_W-1:0]   raw_mag;
  logic                        b_neg_d;
  logic [csu_pkg::PAY_W-1:0]   b_mag_d;

  csu_extract u_extract (
    .cfg_i     (cfg_q),
    .payload_i (a_payload_q),
    .ext_o     (ext)
  );

  always_comb begin
    if (a_id_q != cfg_q.expected_id) begin
      b_status_d = csu_pkg::STATUS_ID_MISMATCH;
    end else if (a_len_q != cfg_q.expected_length) begin
      b_status_d = csu_pkg::STATUS_LEN_MISMATCH;
    end else begin
      b_status_d = csu_pkg::STATUS_OK;
    end
  end

  // The raw value always lies between the field's extremes, so the clamp only
  // matters for a negative factor, where it always yields the scaled maximum.
  assign f_neg   = cfg_q.factor_q16[csu_pkg::FACT_W-1];
  assign f_mag   = f_neg ? (csu_pkg::FACT_W'(0) - cfg_q.factor_q16) : cfg_q.factor_q16;
  assign raw_neg = cfg_q.signed_value & ext.raw[csu_pkg::PAY_W-1];
  assign raw_mag = raw_neg ? (csu_pkg::PAY_W'(0) - ext.raw) : ext.raw;
  assign b_neg_d = f_neg ? 1'b1 : raw_neg;
  assign b_mag_d = f_neg ? ext.maxmag : raw_mag;

  // Stage B: extracted field and operands.
  csu_pkg::status_e           b_status_q;
  logic [csu_pkg::PAY_W-1:0]  b_raw_q;
  logic                       b_neg_q;
  logic [csu_pkg::PAY_W-1:0]  b_mag_q;
  logic [csu_pkg::FACT_W-1:0] b_fmag_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_valid_q) begin
      b_status_q <= b_status_d;
      b_raw_q    <= ext.raw;
      b_neg_q    <= b_neg_d;
      b_mag_q    <= b_mag_d;
      b_fmag_q   <= f_mag;
    end
  end

  // Stage C: partial products.
  csu_pkg::status_e          c_status_q;
  logic [csu_pkg::PAY_W-1:0] c_raw_q;
  logic                      c_neg_q;
  logic [csu_pkg::PAY_W-1:0] c_p0_q;
  logic [csu_pkg::PAY_W-1:0] c_p1_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c && b_valid_q) begin
      c_status_q <= b_status_q;
      c_raw_q    <= b_raw_q;
      c_neg_q    <= b_neg_q;
      c_p0_q     <= csu_pkg::PAY_W'(b_mag_q[31:0]) * csu_pkg::PAY_W'(b_fmag_q);
      c_p1_q     <= csu_pkg::PAY_W'(b_mag_q[63:32]) * csu_pkg::PAY_W'(b_fmag_q);
    end
  end

  // Stage D: full product magnitude.
  csu_pkg::status_e           d_status_q;
  logic [csu_pkg::PAY_W-1:0]  d_raw_q;
  logic                       d_neg_q;
  logic [csu_pkg::PROD_W-1:0] d_prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_valid_q) begin
      d_status_q <= c_status_q;
      d_raw_q    <= c_raw_q;
      d_neg_q    <= c_neg_q;
      d_prod_q   <= csu_pkg::PROD_W'(c_p0_q) + {c_p1_q, 32'd0};
    end
  end

  // Output stage: signed product plus offset, saturated to 64 bits; both values read zero when the frame check fails.
  logic [csu_pkg::SUM_W-1:0] prod_s;
  logic [csu_pkg::SUM_W-1:0] off_ext;
  logic [csu_pkg::SUM_W-1:0] sum;
  logic                      fits;
  logic [csu_pkg::PAY_W-1:0] sat;
  logic                      ok;

  assign prod_s  = d_neg_q ? ~{1'b0, d_prod_q} : {1'b0, d_prod_q};
  assign off_ext = {{(csu_pkg::SUM_W-csu_pkg::OFF_W){cfg_q.offset_q16[csu_pkg::OFF_W-1]}},
                    cfg_q.offset_q16};
  assign sum     = prod_s + off_ext + csu_pkg::SUM_W'(d_neg_q);
  assign fits    = (sum[csu_pkg::SUM_W-1:csu_pkg::PAY_W-1] == '0) ||
                   (sum[csu_pkg::SUM_W-1:csu_pkg::PAY_W-1] == '1);
  assign sat     = fits ? sum[csu_pkg::PAY_W-1:0]
                 : (sum[csu_pkg::SUM_W-1] ? {1'b1, {(csu_pkg::PAY_W-1){1'b0}}}
                                          : {1'b0, {(csu_pkg::PAY_W-1){1'b1}}});
  assign ok      = (d_status_q == csu_pkg::STATUS_OK);

  csu_pkg::status_e          o_status_q;
  logic [csu_pkg::PAY_W-1:0] o_raw_q;
  logic [csu_pkg::PAY_W-1:0] o_scaled_q;

  always_ff @(posedge clk_i) begin
    if (rdy_o && d_valid_q) begin
      o_status_q <= d_status_q;
      o_raw_q    <= ok ? d_raw_q : '0;
      o_scaled_q <= ok ? sat : '0;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {6'd0, o_scaled_q, o_raw_q, o_status_q};

endmodule

`default_nettype wire

### test/can_signal_unpack_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for can_signal_unpack: frame check, signal extraction and scaling.
// Holds its own decoder model in a small scoreboard class; depends on csu_pkg and the RTL.

typedef struct {
  csu_pkg::status_e status;
  logic [63:0]      raw;
  logic [63:0]      scaled;
} frame_result_t;

class signal_decoder_model;
  logic [28:0]        exp_id;
  logic [3:0]         exp_len;
  logic [5:0]         start;
  logic [6:0]         bit_len;
  bit                 intel;
  bit                 sgn;
  logic signed [31:0] factor;
  logic signed [47:0] offset;
  frame_result_t      expected_decodes[$];
  int                 errors;

  function new();
    exp_id   = '0;
    exp_len  = 4'd8;
    start    = '0;
    bit_len  = 7'd8;
    intel    = 1'b1;
    sgn      = 1'b0;
    factor   = 32'sd65536;
    offset   = '0;
    errors   = 0;
  endfunction

  function void set_reg(csu_pkg::reg_idx_e idx, logic [47:0] d);
    case (idx)
      csu_pkg::REG_EXPECTED_ID:     exp_id = d[28:0];
      csu_pkg::REG_EXPECTED_LENGTH: exp_len = d[3:0];
      csu_pkg::REG_START_BIT:       start = d[5:0];
      csu_pkg::REG_BIT_LENGTH:      bit_len = d[6:0];
      csu_pkg::REG_INTEL_ORDER:     intel = d[0];
      csu_pkg::REG_SIGNED_VALUE:    sgn = d[0];
      csu_pkg::REG_FACTOR_Q16:      factor = d[31:0];
      csu_pkg::REG_OFFSET_Q16:      offset = d[47:0];
      default: ;
    endcase
  endfunction

  // Exact fixed-point scaling: value times factor plus offset in 128 bits.
  function logic signed [127:0] scale_q16(logic signed [64:0] x);
    logic signed [127:0] wx;
    logic signed [127:0] wf;
    logic signed [127:0] wo;
    wx = x;
    wf = factor;
    wo = offset;
    return wx * wf + wo;
  endfunction

  function void note_frame(logic [28:0] id, logic [3:0] len, logic [63:0] pay);
    frame_result_t       r;
    int                  width;
    int                  sbi;
    int                  pos;
    int                  t2;
    int                  nsb;
    int                  b0;
    int                  sh;
    int                  t;
    int                  byte_i;
    logic [63:0]         raw;
    logic signed [64:0]  val;
    logic signed [64:0]  lo_raw;
    logic signed [64:0]  hi_raw;
    logic signed [127:0] v;
    logic signed [127:0] lo;
    logic signed [127:0] hi;
    r.status = csu_pkg::STATUS_OK;
    r.raw    = '0;
    r.scaled = '0;
    if (id != exp_id) begin
      r.status = csu_pkg::STATUS_ID_MISMATCH;
    end else if (len != exp_len) begin
      r.status = csu_pkg::STATUS_LEN_MISMATCH;
    end else begin
      width = (bit_len == 0) ? 1 : ((bit_len > 64) ? 64 : int'(bit_len));
      sbi = int'(start);
      raw = '0;
      if (intel) begin
        for (int i = 0; i < width; i++) begin
          pos = sbi + i;
          if (pos < 64) raw[i] = pay[pos];
        end
      end else begin
        t2  = (sbi / 8) * 8 + 7 - sbi % 8 + width - 1;
        nsb = (t2 / 8) * 8 + 7 - t2 % 8;
        b0  = nsb / 8;
        sh  = nsb % 8;
        for (int i = 0; i < width; i++) begin
          t = sh + i;
          byte_i = b0 - t / 8;
          if (byte_i >= 0 && byte_i <= 7) raw[i] = pay[byte_i * 8 + t % 8];
        end
      end
      if (sgn && raw[width-1] && width < 64) raw = raw | ({64{1'b1}} << width);
      if (sgn) begin
        val    = {raw[63], raw};
        hi_raw = (65'sd1 <<< (width - 1)) - 65'sd1;
        lo_raw = -(hi_raw + 65'sd1);
      end else begin
        val    = {1'b0, raw};
        hi_raw = (65'sd1 <<< width) - 65'sd1;
        lo_raw = '0;
      end
      v  = scale_q16(val);
      lo = scale_q16(lo_raw);
      hi = scale_q16(hi_raw);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      r.raw = raw;
      if (v > 128'sh7FFF_FFFF_FFFF_FFFF) r.scaled = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (v < -128'sh8000_0000_0000_0000) r.scaled = 64'h8000_0000_0000_0000;
      else r.scaled = v[63:0];
    end
    expected_decodes.push_back(r);
  endfunction

  function void mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  function void check_result(logic [1:0] st, logic [63:0] raw, logic [63:0] scaled);
    frame_result_t want;
    if (expected_decodes.size() == 0) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: unexpected transaction, expected none, actual status %0d raw %h scaled %h",
                 $time, st, raw, scaled);
      end
      return;
    end
    want = expected_decodes.pop_front();
    if (st !== want.status) mismatch("status", 64'(want.status), 64'(st));
    if (raw !== want.raw) mismatch("raw_value", want.raw, raw);
    if (scaled !== want.scaled) mismatch("scaled_value", want.scaled, scaled);
  endfunction

  function int pending();
    return expected_decodes.size();
  endfunction
endclass

module can_signal_unpack_tb;

  localparam int HOLD_CYCLES    = 50;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i;
  logic [csu_pkg::CFG_IDX_W-1:0]        cfg_idx_i;
  logic [csu_pkg::CFG_DATA_W-1:0]       cfg_wdata_i;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  logic [csu_pkg::IN_W-1:0]             s_axis_tdata;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  logic [csu_pkg::OUT_W-1:0]            m_axis_tdata;

  bit                  idle_on = 1'b1;
  bit                  hold_output = 1'b0;
  signal_decoder_model decoder;

  can_signal_unpack u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic send_frame(input logic [28:0] id, input logic [3:0] len,
                            input logic [63:0] pay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pay, len, id};
    do @(posedge clk_i); while (!s_axis_tready);
    decoder.note_frame(id, len, pay);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (decoder.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input csu_pkg::reg_idx_e idx, input logic [47:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    decoder.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic configure(input logic [28:0] id, input logic [3:0] len,
                           input logic [5:0] sb, input logic [6:0] bl,
                           input bit intel, input bit sgn,
                           input logic [31:0] f, input logic [47:0] off);
    drain();
    write_reg(csu_pkg::REG_EXPECTED_ID, 48'(id));
    write_reg(csu_pkg::REG_EXPECTED_LENGTH, 48'(len));
    write_reg(csu_pkg::REG_START_BIT, 48'(sb));
    write_reg(csu_pkg::REG_BIT_LENGTH, 48'(bl));
    write_reg(csu_pkg::REG_INTEL_ORDER, 48'(intel));
    write_reg(csu_pkg::REG_SIGNED_VALUE, 48'(sgn));
    write_reg(csu_pkg::REG_FACTOR_Q16, 48'(f));
    write_reg(csu_pkg::REG_OFFSET_Q16, off);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      decoder.check_result(m_axis_tdata[1:0], m_axis_tdata[65:2], m_axis_tdata[129:66]);
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        hold_output = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** can_signal_unpack: FAILED **");
    $finish;
  end

  initial begin
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] pay;
    logic [28:0] cid;
    logic [6:0]  cbl;
    logic [31:0] cf;
    logic [47:0] co;
    logic [31:0] w;
    decoder       = new();
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults after reset, both checks, and the identifier winning over length.
    send_frame(29'd0, 4'd8, '1);
    send_frame(29'd0, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(29'd1, 4'd8, '1);
    send_frame(29'd0, 4'd7, '1);
    send_frame(29'h1FFF_FFFF, 4'hF, '1);
    send_frame(29'd0, 4'd0, '1);

    // Zero width read as one bit, most negative factor so the upper bound always wins.
    configure(29'h1FFF_FFFF, 4'd0, 6'd63, 7'd0, 1'b1, 1'b1, 32'h8000_0000, 48'h7FFF_FFFF_FFFF);
    send_frame(29'h1FFF_FFFF, 4'd0, '1);
    send_frame(29'h1FFF_FFFF, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_frame(29'h1FFF_FFFF, 4'd0, '0);

    // Width above 64, largest factor, most negative offset: saturation to 64 bits.
    configure(29'h0AAA_AAAA, 4'd8, 6'd0, 7'd127, 1'b1, 1'b0, 32'h7FFF_FFFF, 48'h8000_0000_0000);
    send_frame(29'h0AAA_AAAA, 4'd8, '1);
    send_frame(29'h0AAA_AAAA, 4'd8, '0);
    send_frame(29'h0AAA_AAAA, 4'd8, 64'h8000_0000_0000_0000);

    // Full-width signed Motorola field.
    configure(29'h1555_5555, 4'd8, 6'd7, 7'd64, 1'b0, 1'b1, 32'd65536, 48'd0);
    send_frame(29'h1555_5555, 4'd8, '1);
    send_frame(29'h1555_5555, 4'd8, 64'h80);
    send_frame(29'h1555_5555, 4'd8, 64'h0123_4567_89AB_CDEF);

    // Fields that run off the end of the payload, Intel and then Motorola.
    configure(29'h123, 4'd4, 6'd60, 7'd20, 1'b1, 1'b1, 32'hFFFF_0000, 48'h0000_0001_0000);
    send_frame(29'h123, 4'd4, '1);
    send_frame(29'h123, 4'd4, 64'hF000_0000_0000_0000);
    configure(29'h456, 4'd8, 6'd62, 7'd20, 1'b0, 1'b0, 32'h0001_8000, 48'hFFFF_FFFF_0000);
    send_frame(29'h456, 4'd8, '1);
    send_frame(29'h456, 4'd8, {$urandom, $urandom});

    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0: cid = '0;
        1: cid = 29'h1FFF_FFFF;
        default: cid = 29'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: cbl = 7'($urandom_range(0, 127));
        1: cbl = 7'd64;
        default: cbl = 7'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 3))
        0: cf = $urandom;
        1: cf = 32'(int'($urandom_range(0, 262144)) - 131072);
        2: cf = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
        default: cf = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      w = $urandom;
      case ($urandom_range(0, 2))
        0: co = {w[15:0], $urandom};
        1: co = {{16{w[31]}}, w};
        default: co = '0;
      endcase
      configure(cid, 4'($urandom_range(0, 8)), 6'($urandom_range(0, 63)), cbl,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cf, co);
      idle_on = (phase < 8) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        @(posedge clk_i);
        hold_output = 1'b1;
      end
      repeat (40) begin
        id  = decoder.exp_id;
        len = decoder.exp_len;
        case ($urandom_range(0, 9))
          0: id = 29'($urandom);
          1: len = 4'($urandom_range(0, 15));
          default: ;
        endcase
        pay = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: pay = '0;
          1: pay = '1;
          2: pay = 64'd1 << $urandom_range(0, 63);
          default: ;
        endcase
        send_frame(id, len, pay);
      end
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (decoder.errors == 0 && decoder.pending() == 0) begin
      $display("** can_signal_unpack: PASSED **");
    end else begin
      $display("** can_signal_unpack: FAILED **");
    end
    $finish;
  end

endmodule
